// ----- design/baudot_mtk2_text_encoder_assert.svh -----
// Assertion macros shared by the encoder modules. They sample on clk and are
// held off while rst_n is low.
`ifndef BAUDOT_MTK2_TEXT_ENCODER_ASSERT_SVH
`define BAUDOT_MTK2_TEXT_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

`define BME_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("encoder assertion failed");

`define BME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`else

`define BME_ASSERT_IMP(label, ante, cons)

`define BME_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/bme_pkg.sv -----
package bme_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SH_LAT = 2'd0,
    SH_FIG = 2'd1,
    SH_RUS = 2'd2
  } shift_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_END   = 2'd2
  } code_kind_t;

  localparam logic [4:0] CODE_SHIFT_LAT = 5'h1F;
  localparam logic [4:0] CODE_SHIFT_FIG = 5'h1B;
  localparam logic [4:0] CODE_SHIFT_RUS = 5'h00;
  localparam logic [4:0] CODE_SPACE     = 5'h04;
  localparam logic [4:0] CODE_LF        = 5'h08;
  localparam logic [4:0] CODE_CR        = 5'h02;

  localparam logic [7:0] NO_MATCH   = 8'hFF;
  localparam logic [7:0] LEAD_D0    = 8'hD0;
  localparam logic [7:0] LEAD_D1    = 8'hD1;
  localparam logic [7:0] ASCII_SP   = 8'h20;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_CR   = 8'h0D;

  // Table entries are {shift, code}: shift in bits 6:5, code in bits 4:0.
  localparam logic [7:0] CYR_MAP [32] = '{
    8'h43, 8'h59, 8'h53, 8'h5A, 8'h49, 8'h41, 8'h5E, 8'h51,
    8'h46, 8'h4B, 8'h4F, 8'h52, 8'h5C, 8'h4C, 8'h58, 8'h56,
    8'h4A, 8'h45, 8'h50, 8'h47, 8'h4D, 8'h54, 8'h4E, 8'h2A,
    8'h3A, 8'h34, 8'h5D, 8'h55, 8'h5D, 8'h2D, 8'h2B, 8'h57
  };

  localparam logic [4:0] LAT_MAP [26] = '{
    5'h03, 5'h19, 5'h0E, 5'h09, 5'h01, 5'h0D, 5'h1A, 5'h14, 5'h06,
    5'h0B, 5'h0F, 5'h12, 5'h1C, 5'h0C, 5'h18, 5'h16, 5'h17, 5'h0A,
    5'h05, 5'h10, 5'h07, 5'h1E, 5'h13, 5'h1D, 5'h15, 5'h11
  };

  localparam logic [4:0] DIGIT_MAP [10] = '{
    5'h16, 5'h17, 5'h13, 5'h01, 5'h0A, 5'h10, 5'h15, 5'h07, 5'h06, 5'h18
  };

  // One queue entry: what the back end has to send for one item.
  typedef struct packed {
    logic       send_shift;
    logic       send_char;
    logic       send_end;
    logic [4:0] shift_code;
    logic [4:0] char_code;
  } plan_t;

  function automatic logic [7:0] lookup_single(input logic [7:0] b);
    logic [7:0] e;
    e = NO_MATCH;
    if (b >= 8'h41 && b <= 8'h5A) begin
      e = {3'b000, LAT_MAP[5'(b - 8'h41)]};
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      e = {3'b000, LAT_MAP[5'(b - 8'h61)]};
    end else if (b >= 8'h30 && b <= 8'h39) begin
      e = {3'b001, DIGIT_MAP[4'(b - 8'h30)]};
    end else begin
      case (b)
        8'h2D:   e = 8'h23;
        8'h3F:   e = 8'h39;
        8'h3A:   e = 8'h2E;
        8'h28:   e = 8'h2F;
        8'h29:   e = 8'h32;
        8'h2E:   e = 8'h3C;
        8'h2C:   e = 8'h2C;
        8'h27:   e = 8'h25;
        8'h3D:   e = 8'h3E;
        8'h2F:   e = 8'h3D;
        8'h2B:   e = 8'h31;
        default: e = NO_MATCH;
      endcase
    end
    return e;
  endfunction

  function automatic logic [7:0] lookup_pair(input logic [7:0] lead, input logic [7:0] cont);
    logic [7:0] e;
    e = NO_MATCH;
    if (lead == LEAD_D0) begin
      if (cont == 8'h81) begin
        e = 8'h41;
      end else if (cont >= 8'h90 && cont <= 8'hBF) begin
        // The upper part of the range folds back onto the start of the table.
        e = CYR_MAP[{~cont[4], cont[3:0]}];
      end
    end else if (lead == LEAD_D1) begin
      if (cont == 8'h91) begin
        e = 8'h41;
      end else if (cont >= 8'h80 && cont <= 8'h8F) begin
        e = CYR_MAP[{1'b1, cont[3:0]}];
      end
    end
    return e;
  endfunction

  function automatic logic [4:0] shift_code_of(input shift_t s);
    logic [4:0] c;
    case (s)
      SH_LAT:  c = CODE_SHIFT_LAT;
      SH_FIG:  c = CODE_SHIFT_FIG;
      SH_RUS:  c = CODE_SHIFT_RUS;
      default: c = CODE_SHIFT_RUS;
    endcase
    return c;
  endfunction

endpackage

// ----- design/bme_if.sv -----
interface bme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       message_start;
  logic       message_end;

  modport source(output valid, output text_byte, output byte_present,
                 output message_start, output message_end, input ready);
  modport sink(input valid, input text_byte, input byte_present,
               input message_start, input message_end, output ready);
endinterface

interface bme_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] baudot_code;
  logic [1:0] code_kind;
  logic       last_of_run;

  modport source(output valid, output baudot_code, output code_kind,
                 output last_of_run, input ready);
  modport sink(input valid, input baudot_code, input code_kind,
               input last_of_run, output ready);
endinterface

// ----- design/baudot_mtk2_text_encoder.sv -----
// MTK-2 text encoder: takes UTF-8 text one byte per beat and sends 5-bit
// MTK-2 codes, inserting Latin, figure or Russian shift codes as needed and
// appending CR LF at message end. The front end accepts one input beat per
// clock as long as its two-entry plan queue has room; the back end sends one
// code per clock while the sink takes its output. An item causes one to four
// codes (a shift, a character, then CR and LF); an item that causes no code
// never enters the queue. When the back end has drained its work, it loads
// the next queued item before picking its first code. The output register
// lets a code wait for the sink while the next one is already being prepared.
module baudot_mtk2_text_encoder (
  input  logic       clk,
  input  logic       rst_n,
  bme_in_if.sink     in_ch,
  bme_out_if.source  out_ch
);
  import bme_pkg::*;

  plan_t push_plan;
  plan_t pop_plan;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  bme_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_plan (push_plan)
  );

  bme_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_plan (push_plan),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_plan  (pop_plan)
  );

  bme_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_plan  (pop_plan),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- design/bme_front.sv -----
module bme_front (
  input  logic          clk,
  input  logic          rst_n,
  bme_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output bme_pkg::plan_t q_plan
);
  import bme_pkg::*;

  shift_t     shift_r, shift_nxt;
  logic [7:0] held_lead_r, held_lead_nxt;
  logic       lead_held_r, lead_held_nxt;

  logic       accept;
  shift_t     shift_eff;
  logic       lead_eff;
  logic [7:0] pair_entry;
  logic [7:0] single_entry;
  logic [7:0] entry;
  logic       plain_en;
  logic [4:0] plain_code;
  logic       char_en;
  shift_t     target;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pair_entry   = lookup_pair(held_lead_r, in_ch.text_byte);
  assign single_entry = lookup_single(in_ch.text_byte);

  always_comb begin
    shift_eff     = in_ch.message_start ? SH_LAT : shift_r;
    lead_eff      = lead_held_r && !in_ch.message_start;
    lead_held_nxt = lead_eff;
    held_lead_nxt = held_lead_r;
    entry         = NO_MATCH;
    plain_en      = 1'b0;
    plain_code    = CODE_SPACE;

    if (in_ch.byte_present) begin
      // A held lead is used up by any following byte, matched or not.
      lead_held_nxt = 1'b0;
      if (lead_eff && pair_entry != NO_MATCH) begin
        entry = pair_entry;
      end else if (in_ch.text_byte == ASCII_SP) begin
        plain_en   = 1'b1;
        plain_code = CODE_SPACE;
      end else if (in_ch.text_byte == ASCII_LF) begin
        plain_en   = 1'b1;
        plain_code = CODE_LF;
      end else if (in_ch.text_byte == ASCII_CR) begin
        plain_en   = 1'b1;
        plain_code = CODE_CR;
      end else if (single_entry != NO_MATCH) begin
        entry = single_entry;
      end else if (in_ch.text_byte == LEAD_D0 || in_ch.text_byte == LEAD_D1) begin
        lead_held_nxt = 1'b1;
        held_lead_nxt = in_ch.text_byte;
      end
    end

    if (in_ch.message_end) begin
      lead_held_nxt = 1'b0;
    end

    char_en   = plain_en || (entry != NO_MATCH);
    target    = (entry != NO_MATCH) ? shift_t'(entry[6:5]) : shift_eff;
    shift_nxt = target;

    q_plan.send_shift = (entry != NO_MATCH) && (target != shift_eff);
    q_plan.send_char  = char_en;
    q_plan.send_end   = in_ch.message_end;
    q_plan.shift_code = shift_code_of(target);
    q_plan.char_code  = plain_en ? plain_code : entry[4:0];
  end

  // Items that produce no code are absorbed here and never reach the queue.
  assign q_push = accept && (char_en || in_ch.message_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= SH_LAT;
      lead_held_r <= 1'b0;
    end else if (accept) begin
      shift_r     <= shift_nxt;
      lead_held_r <= lead_held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_lead_r <= held_lead_nxt;
    end
  end

endmodule

// ----- design/bme_fifo.sv -----
module bme_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bme_pkg::plan_t push_plan,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bme_pkg::plan_t pop_plan
);
  import bme_pkg::*;

  `include "baudot_mtk2_text_encoder_assert.svh"

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

  plan_t         slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == DEPTH_CNT);
  assign not_empty = (count_r != '0);
  assign pop_plan  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_plan;
    end
  end

  `BME_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_CNT)
  `BME_ASSERT_IMP(a_no_push_full, push, !full)
  `BME_ASSERT_NEXT(a_count_follows, do_push && !do_pop, count_r == $past(count_r) + 1'b1)

endmodule

// ----- design/bme_back.sv -----
module bme_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bme_pkg::plan_t q_plan,
  output logic           q_pop,
  bme_out_if.source      out_ch
);
  import bme_pkg::*;

  `include "baudot_mtk2_text_encoder_assert.svh"

  // Pending codes of the current item, lowest bit goes first:
  // bit 0 shift, bit 1 character, bit 2 CR, bit 3 LF.
  logic [3:0]  mask_r, mask_nxt;
  logic [4:0]  shift_code_r;
  logic [4:0]  char_code_r;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_code_r;
  code_kind_t  out_kind_r;
  logic        out_last_r;

  logic        advance;
  logic        load;
  logic [3:0]  rest;
  logic        last;
  logic [4:0]  sel_code;
  code_kind_t  sel_kind;

  assign advance = (mask_r != '0) && (!out_valid_r || out_ch.ready);
  assign rest    = mask_r & (mask_r - 4'd1);
  assign last    = (rest == '0);
  assign load    = q_valid && ((mask_r == '0) || (advance && last));
  assign q_pop   = load;

  always_comb begin
    if (mask_r[0]) begin
      sel_code = shift_code_r;
      sel_kind = KIND_SHIFT;
    end else if (mask_r[1]) begin
      sel_code = char_code_r;
      sel_kind = KIND_CHAR;
    end else if (mask_r[2]) begin
      sel_code = CODE_CR;
      sel_kind = KIND_END;
    end else begin
      sel_code = CODE_LF;
      sel_kind = KIND_END;
    end
  end

  always_comb begin
    if (load) begin
      mask_nxt = {q_plan.send_end, q_plan.send_end, q_plan.send_char, q_plan.send_shift};
    end else if (advance) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_code_r <= q_plan.shift_code;
      char_code_r  <= q_plan.char_code;
    end
    if (advance) begin
      out_code_r <= sel_code;
      out_kind_r <= sel_kind;
      out_last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.baudot_code = out_code_r;
  assign out_ch.code_kind   = out_kind_r;
  assign out_ch.last_of_run = out_last_r;

  `BME_ASSERT_IMP(a_shift_not_last, out_valid_r && out_kind_r == KIND_SHIFT, !out_last_r)
  `BME_ASSERT_IMP(a_cr_not_last,
                  out_valid_r && out_kind_r == KIND_END && out_code_r == CODE_CR, !out_last_r)
  `BME_ASSERT_NEXT(a_run_continues, advance && !last, mask_r != '0)

endmodule
